// ----- hw/rtl/full_duplex_uart_bit_engine_core_assert.svh -----
// Assertion macros shared by the checker of the UART bit engine.
// Each macro expands to one labeled concurrent assertion clocked on clk
// and disabled while rst is high.
`ifndef FULL_DUPLEX_UART_BIT_ENGINE_CORE_ASSERT_SVH
`define FULL_DUPLEX_UART_BIT_ENGINE_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FDUB_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FDUB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/fdub_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package fdub_pkg;

  // Bit period register.
  localparam int unsigned BIT_TICKS_W = 16;
  localparam logic [BIT_TICKS_W-1:0] BIT_TICKS_RESET = 16'd104;

  // Configuration port geometry: one 32-bit register at byte address 0.
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_BIT_TICKS = 1'd0;

  // Frame geometry.
  localparam int unsigned TX_FRAME_W = 10;
  localparam logic [3:0] TX_FRAME_BITS = 4'd10;
  localparam logic [3:0] RX_DATA_BITS = 4'd8;
  localparam int unsigned RX_TIMER_W = BIT_TICKS_W + 1;

  typedef enum logic [1:0] {
    RX_WAIT = 2'd0,
    RX_BUSY = 2'd1
  } rx_phase_t;

  typedef struct packed {
    logic       rx_line;
    logic       tx_load;
    logic [7:0] tx_byte;
  } item_t;

  typedef struct packed {
    logic       tx_line;
    logic       tx_busy;
    logic       rx_valid;
    logic [7:0] rx_byte;
  } result_t;

  typedef struct packed {
    logic line;
    logic busy;
  } tx_status_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } rx_status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/fdub_tx.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fdub_tx (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                step,
  input  logic                                load,
  input  logic [7:0]                          data,
  input  logic [fdub_pkg::BIT_TICKS_W-1:0]    bit_ticks,
  output fdub_pkg::tx_status_t                status_next
);
  import fdub_pkg::*;

  logic [TX_FRAME_W-1:0]  shift, shift_next;
  logic [3:0]             bits_left, bits_left_next;
  logic [BIT_TICKS_W-1:0] timer, timer_next;
  logic                   active, active_next;
  logic                   out, out_next;
  logic                   expire;

  // A timer holding zero or one runs out on this tick.
  assign expire = (timer <= {{(BIT_TICKS_W-1){1'b0}}, 1'b1});

  always_comb begin
    shift_next     = shift;
    bits_left_next = bits_left;
    timer_next     = timer;
    active_next    = active;
    out_next       = out;
    if (active) begin
      if (expire) begin
        timer_next = bit_ticks;
        if (bits_left == 4'd0) begin
          active_next = 1'b0;
        end else begin
          out_next       = shift[0];
          shift_next     = {1'b0, shift[TX_FRAME_W-1:1]};
          bits_left_next = bits_left - 4'd1;
        end
      end else begin
        timer_next = timer - {{(BIT_TICKS_W-1){1'b0}}, 1'b1};
      end
    end else if (load) begin
      // Stop bit, data LSB first, start bit in the low position.
      shift_next     = {1'b1, data, 1'b0};
      bits_left_next = TX_FRAME_BITS;
      timer_next     = bit_ticks;
      active_next    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift     <= '1;
      bits_left <= '0;
      timer     <= '0;
      active    <= 1'b0;
      out       <= 1'b1;
    end else if (step) begin
      shift     <= shift_next;
      bits_left <= bits_left_next;
      timer     <= timer_next;
      active    <= active_next;
      out       <= out_next;
    end
  end

  assign status_next.line = out_next;
  assign status_next.busy = active_next;

endmodule

`default_nettype wire

// ----- hw/rtl/fdub_rx.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fdub_rx (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                step,
  input  logic                                line,
  input  logic [fdub_pkg::BIT_TICKS_W-1:0]    bit_ticks,
  output fdub_pkg::rx_status_t                status_next
);
  import fdub_pkg::*;

  rx_phase_t             phase, phase_next;
  logic [RX_TIMER_W-1:0] timer, timer_next;
  logic [7:0]            shift, shift_next;
  logic [3:0]            bits_left, bits_left_next;
  logic                  prev_level;
  logic [7:0]            hold, hold_next;
  logic                  valid_next;
  logic                  expire;
  logic                  fall;
  logic                  last_bit;
  logic [RX_TIMER_W-1:0] start_delay;

  assign expire   = (timer <= {{(RX_TIMER_W-1){1'b0}}, 1'b1});
  assign fall     = prev_level && !line;
  assign last_bit = (bits_left == 4'd1);
  // One and a half bit periods puts the first sample in the middle of bit 0.
  assign start_delay = {1'b0, bit_ticks} + {2'b00, bit_ticks[BIT_TICKS_W-1:1]};

  always_comb begin
    phase_next = phase;
    case (phase)
      RX_WAIT: begin
        if (fall) begin
          phase_next = RX_BUSY;
        end
      end
      default: begin
        if (expire && last_bit) begin
          phase_next = RX_WAIT;
        end
      end
    endcase
  end

  always_comb begin
    timer_next     = timer;
    shift_next     = shift;
    bits_left_next = bits_left;
    hold_next      = hold;
    valid_next     = 1'b0;
    case (phase)
      RX_WAIT: begin
        if (fall) begin
          timer_next     = start_delay;
          bits_left_next = RX_DATA_BITS;
        end
      end
      default: begin
        if (expire) begin
          shift_next = {line, shift[7:1]};
          if (last_bit) begin
            hold_next      = {line, shift[7:1]};
            valid_next     = 1'b1;
            bits_left_next = RX_DATA_BITS;
          end else begin
            bits_left_next = bits_left - 4'd1;
            timer_next     = {1'b0, bit_ticks};
          end
        end else begin
          timer_next = timer - {{(RX_TIMER_W-1){1'b0}}, 1'b1};
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= RX_WAIT;
      timer      <= '0;
      shift      <= '0;
      bits_left  <= RX_DATA_BITS;
      prev_level <= 1'b1;
      hold       <= '0;
    end else if (step) begin
      phase      <= phase_next;
      timer      <= timer_next;
      shift      <= shift_next;
      bits_left  <= bits_left_next;
      prev_level <= line;
      hold       <= hold_next;
    end
  end

  assign status_next.valid = valid_next;
  assign status_next.data  = hold_next;

endmodule

`default_nettype wire

// ----- hw/rtl/full_duplex_uart_bit_engine_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Latency: the result of an item appears in the cycle after its beat is accepted.
// Throughput: one item per cycle; the single result register sets this, and the
// input side stalls only while that register holds a beat the sink is stalling.
// Reset (rst, synchronous, active high) puts the transmitter idle at mark, the
// receiver waiting for a start edge, bit_ticks at 104 and the result empty.

module full_duplex_uart_bit_engine_core (
  input  logic                               clk,
  input  logic                               rst,
  // Input items, one per bit-timer tick.
  input  logic                               item_valid,
  output logic                               item_stall,
  input  fdub_pkg::item_t                    item,
  // Result items, one per input item.
  output logic                               result_valid,
  input  logic                               result_stall,
  output fdub_pkg::result_t                  result,
  // Configuration port.
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [fdub_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [fdub_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [fdub_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready
);
  import fdub_pkg::*;

  logic [BIT_TICKS_W-1:0] bit_ticks;
  logic                   reg_hit;
  logic                   cfg_write;
  logic                   step;
  tx_status_t             tx_next;
  rx_status_t             rx_next;

  // The configuration port never inserts wait states. The register index is
  // the word address; the two low address bits select a byte and are ignored.
  assign pready    = 1'b1;
  assign reg_hit   = (paddr[APB_ADDR_W-1:2] == REG_BIT_TICKS);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_ticks <= BIT_TICKS_RESET;
    end else if (cfg_write && reg_hit) begin
      bit_ticks <= pwdata[BIT_TICKS_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_hit) begin
      prdata = {{(APB_DATA_W-BIT_TICKS_W){1'b0}}, bit_ticks};
    end
  end

  // An item is taken whenever the result register is empty or being drained,
  // so the engine advances one tick per accepted beat.
  assign item_stall = result_valid && result_stall;
  assign step       = item_valid && !item_stall;

  // Transmit and receive halves each hold their own state and present the
  // values that state takes after this tick's update.
  fdub_tx u_tx (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .load        (item.tx_load),
    .data        (item.tx_byte),
    .bit_ticks   (bit_ticks),
    .status_next (tx_next)
  );

  fdub_rx u_rx (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .line        (item.rx_line),
    .bit_ticks   (bit_ticks),
    .status_next (rx_next)
  );

  // Result register. It is loaded on each accepted item and empties when the
  // sink takes the beat without a new item arriving behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (step) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      result.tx_line  <= tx_next.line;
      result.tx_busy  <= tx_next.busy;
      result.rx_valid <= rx_next.valid;
      result.rx_byte  <= rx_next.data;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/fdub_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "full_duplex_uart_bit_engine_core_assert.svh"

module fdub_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_stall,
  input logic              result_valid,
  input logic              result_stall,
  input fdub_pkg::result_t result
);
  import fdub_pkg::*;

  logic result_beat;

  assign result_beat = result_valid && !result_stall;

  `FDUB_ASSERT_NEXT(a_result_held, result_valid && result_stall, result_valid && $stable(result), "stalled result beat changed")

  `FDUB_ASSERT_SAME(a_stall_only_when_full, item_stall, result_valid && result_stall, "input stalled while result register free")

  `FDUB_ASSERT_NEXT(a_item_gives_result, item_valid && !item_stall, result_valid, "accepted item produced no result")

  `FDUB_ASSERT_NEXT(a_rx_valid_single, result_beat && result.rx_valid, !(result_beat && result.rx_valid), "receive valid on two back-to-back ticks")

  `FDUB_ASSERT_SAME(a_idle_at_mark, result_valid && !result.tx_busy, result.tx_line, "idle transmitter not at mark")

endmodule

bind full_duplex_uart_bit_engine_core fdub_checker u_fdub_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

`default_nettype wire
